>>> design/stbs_pkg.sv
package stbs_pkg;

   // field widths
   localparam int SYM_W   = 8;
   localparam int CONF_W  = 8;
   localparam int SOFT_W  = 8;
   localparam int BPS_W   = 4;
   localparam int QMAX_W  = 8;

   // soft bit mapping
   localparam int MAX_BITS   = 8;
   localparam int IDX_W      = $clog2(MAX_BITS);
   localparam int NUM_W      = 16;
   localparam int DIV_W      = QMAX_W + 1;
   localparam int REM_W      = DIV_W + 1;
   localparam int QUO_W      = 8;
   localparam logic [SOFT_W-1:0] SOFT_CENTER = 8'd128;
   localparam logic [SOFT_W-1:0] SOFT_TOP    = 8'd255;
   localparam logic [SOFT_W-1:0] SOFT_BOTTOM = 8'd0;
   localparam logic [QUO_W-1:0]  ONE_LIMIT   = 8'd127;
   localparam logic [QUO_W-1:0]  ZERO_LIMIT  = 8'd128;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BITS_PER_SYMBOL = 1'b0,
      CSR_QUANT_MAX       = 1'b1
   } csr_index_type;

   localparam logic [BPS_W-1:0]  BPS_RESET  = 4'd2;
   localparam logic [QMAX_W-1:0] QMAX_RESET = 8'd7;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [BPS_W-1:0]  bits_per_symbol;
      logic [QMAX_W-1:0] quant_max;
   } stbs_cfg_type;

   // one classified and scaled symbol waiting for serialization
   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic [SOFT_W-1:0] one_val;
      logic [SOFT_W-1:0] zero_val;
      logic [BPS_W-1:0]  nbits;
   } stbs_entry_type;

endpackage

>>> design/stbs_channel_ifs.sv
interface stbs_req_if import stbs_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SYM_W-1:0]  symbol;
   logic [CONF_W-1:0] confidence;

   modport source (output valid, output symbol, output confidence, input ready);
   modport sink   (input valid, input symbol, input confidence, output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SOFT_W-1:0] softbit;
   logic              last;

   modport source (output valid, output softbit, output last, input ready);
   modport sink   (input valid, input softbit, input last, output ready);
endinterface

>>> design/stbs_front.sv
module stbs_front import stbs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  stbs_cfg_type   cfg,
   stbs_req_if.sink       req_chan,
   output logic           push_valid,
   input  logic           push_ready,
   output stbs_entry_type push_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_PUSH = 3'b100
   } front_state_type;

   // one restoring step: returns {quotient bit, new partial remainder}
   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                               input logic b,
                                               input logic [DIV_W-1:0] d);
      logic [REM_W-1:0] t;
      t = {r[REM_W-2:0], b};
      if (t >= {1'b0, d}) begin
         div_step = {1'b1, t - {1'b0, d}};
      end else begin
         div_step = {1'b0, t};
      end
   endfunction

   front_state_type   state_ff, state_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [BPS_W-1:0]  nbits_ff, nbits_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [REM_W-1:0]  rem0_ff, rem0_in, rem1_ff, rem1_in;
   logic [7:0]        low0_ff, low0_in, low1_ff, low1_in;
   logic [QUO_W-1:0]  quo0_ff, quo0_in, quo1_ff, quo1_in;
   logic              ovf0_ff, ovf0_in, ovf1_ff, ovf1_in;

   logic [BPS_W-1:0]  nbits_eff;
   logic [QMAX_W-1:0] q_eff;
   logic [NUM_W-1:0]  num0, num1;
   logic              accept;
   logic [REM_W:0]    s0a, s0b, s1a, s1b;

   assign nbits_eff = (cfg.bits_per_symbol > BPS_W'(MAX_BITS)) ? BPS_W'(MAX_BITS)
                                                               : cfg.bits_per_symbol;
   assign q_eff = (cfg.quant_max == '0) ? QMAX_W'(1) : cfg.quant_max;

   // 256*c + q and 254*c + q
   assign num0 = {req_chan.confidence, 8'b0} + {8'b0, q_eff};
   assign num1 = {req_chan.confidence, 8'b0} - {7'b0, req_chan.confidence, 1'b0}
                 + {8'b0, q_eff};

   assign req_chan.ready = (state_ff == S_IDLE) || ((state_ff == S_PUSH) && push_ready);
   assign accept = req_chan.valid && req_chan.ready;

   assign s0a = div_step(rem0_ff, low0_ff[7], div_ff);
   assign s0b = div_step(s0a[REM_W-1:0], low0_ff[6], div_ff);
   assign s1a = div_step(rem1_ff, low1_ff[7], div_ff);
   assign s1b = div_step(s1a[REM_W-1:0], low1_ff[6], div_ff);

   assign push_valid = (state_ff == S_PUSH);

   always_comb begin
      push_data.symbol = sym_ff;
      push_data.nbits  = nbits_ff;
      if (ovf1_ff || (quo1_ff >= ONE_LIMIT)) begin
         push_data.one_val = SOFT_TOP;
      end else begin
         push_data.one_val = SOFT_CENTER + quo1_ff;
      end
      if (ovf0_ff || (quo0_ff >= ZERO_LIMIT)) begin
         push_data.zero_val = SOFT_BOTTOM;
      end else begin
         push_data.zero_val = SOFT_CENTER - quo0_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sym_in   = sym_ff;
      nbits_in = nbits_ff;
      div_in   = div_ff;
      rem0_in  = rem0_ff;
      rem1_in  = rem1_ff;
      low0_in  = low0_ff;
      low1_in  = low1_ff;
      quo0_in  = quo0_ff;
      quo1_in  = quo1_ff;
      ovf0_in  = ovf0_ff;
      ovf1_in  = ovf1_ff;
      case (state_ff)
         S_DIV: begin
            // quotient beyond eight bits only shows in the first check
            if (cnt_ff == 2'd0) begin
               ovf0_in = rem0_ff >= {1'b0, div_ff};
               ovf1_in = rem1_ff >= {1'b0, div_ff};
            end
            rem0_in = s0b[REM_W-1:0];
            rem1_in = s1b[REM_W-1:0];
            low0_in = {low0_ff[5:0], 2'b00};
            low1_in = {low1_ff[5:0], 2'b00};
            quo0_in = {quo0_ff[QUO_W-3:0], s0a[REM_W], s0b[REM_W]};
            quo1_in = {quo1_ff[QUO_W-3:0], s1a[REM_W], s1b[REM_W]};
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // symbols with no bits to send are dropped here
      if (accept && (nbits_eff != '0)) begin
         state_in = S_DIV;
         cnt_in   = 2'd0;
         sym_in   = req_chan.symbol;
         nbits_in = nbits_eff;
         div_in   = {q_eff, 1'b0};
         rem0_in  = {2'b00, num0[15:8]};
         rem1_in  = {2'b00, num1[15:8]};
         low0_in  = num0[7:0];
         low1_in  = num1[7:0];
         quo0_in  = '0;
         quo1_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      sym_ff   <= sym_in;
      nbits_ff <= nbits_in;
      div_ff   <= div_in;
      rem0_ff  <= rem0_in;
      rem1_ff  <= rem1_in;
      low0_ff  <= low0_in;
      low1_ff  <= low1_in;
      quo0_ff  <= quo0_in;
      quo1_ff  <= quo1_in;
      ovf0_ff  <= ovf0_in;
      ovf1_ff  <= ovf1_in;
   end

endmodule

>>> design/stbs_fifo.sv
module stbs_fifo import stbs_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  stbs_entry_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output stbs_entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   stbs_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/stbs_back.sv
module stbs_back import stbs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  stbs_entry_type pop_data,
   stbs_rsp_if.source     rsp_chan
);

   stbs_entry_type    ent_ff, ent_in;
   logic              act_ff, act_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [SOFT_W-1:0] out_soft_ff, out_soft_in;
   logic              out_last_ff, out_last_in;

   logic              adv, cur_last, load;

   assign adv       = act_ff && (!out_valid_ff || rsp_chan.ready);
   assign cur_last  = ({1'b0, idx_ff} + BPS_W'(1)) == ent_ff.nbits;
   assign pop_ready = !act_ff || (adv && cur_last);
   assign load      = pop_valid && pop_ready;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.softbit = out_soft_ff;
   assign rsp_chan.last    = out_last_ff;

   always_comb begin
      ent_in       = ent_ff;
      act_in       = act_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_soft_in  = out_soft_ff;
      out_last_in  = out_last_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (adv) begin
         out_valid_in = 1'b1;
         out_soft_in  = ent_ff.symbol[idx_ff] ? ent_ff.one_val : ent_ff.zero_val;
         out_last_in  = cur_last;
         idx_in       = idx_ff + 1'b1;
         if (cur_last) begin
            act_in = 1'b0;
         end
      end
      if (load) begin
         ent_in = pop_data;
         act_in = 1'b1;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      ent_ff      <= ent_in;
      out_soft_ff <= out_soft_in;
      out_last_ff <= out_last_in;
   end

endmodule

>>> design/symbol_to_soft_bits_unit.sv
// hard symbol to soft bits: each transfer on req_chan (symbol, confidence) turns into
// bits_per_symbol soft bits on rsp_chan, information bit 0 first, with last set on the
// final one. a one bit gives 128 + round(127*c/q), a zero bit 128 - round(128*c/q), half
// up, saturating at 255 and 0 when confidence exceeds quant_max; quant_max of zero acts
// as one, bits_per_symbol above eight acts as eight, and zero bits per symbol drops the
// symbol. the front end scales each symbol with two radix-4 dividers, one per quotient,
// running side by side on the same divisor: it takes the transfer, runs the division and
// then hands the entry to the queue, and while it hands the entry over it can already
// take the next symbol. the back end sends one soft bit per cycle while rsp_chan is ready,
// so a symbol occupies it for bits_per_symbol soft bits. configuration writes take effect
// on the next symbol; they are to be made while idle, which the block itself does not
// enforce
module symbol_to_soft_bits_unit import stbs_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   stbs_req_if.sink               req_chan,
   stbs_rsp_if.source             rsp_chan
);

   // configuration registers
   logic [BPS_W-1:0]  bps_ff, bps_in;
   logic [QMAX_W-1:0] qmax_ff, qmax_in;
   stbs_cfg_type      cfg;

   // queue between divider front and serializer back
   logic              push_valid, push_ready, pop_valid, pop_ready;
   stbs_entry_type    push_data, pop_data;

   always_comb begin
      bps_in  = bps_ff;
      qmax_in = qmax_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BITS_PER_SYMBOL: bps_in  = csr_wdata[BPS_W-1:0];
            CSR_QUANT_MAX:       qmax_in = csr_wdata[QMAX_W-1:0];
            default: begin
               bps_in  = bps_ff;
               qmax_in = qmax_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff  <= BPS_RESET;
         qmax_ff <= QMAX_RESET;
      end else begin
         bps_ff  <= bps_in;
         qmax_ff <= qmax_in;
      end
   end

   assign cfg.bits_per_symbol = bps_ff;
   assign cfg.quant_max       = qmax_ff;

   // takes transfers, clamps the settings and computes both soft values
   stbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   stbs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // picks one or zero value per information bit behind an output register
   stbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> test/stbs_checker.sv
`timescale 1ns / 100ps

module stbs_checker import stbs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   stbs_req_if                    req_mon,
   stbs_rsp_if                    rsp_mon,
   output int                     mismatches,
   output int                     outstanding,
   output int                     softbits_checked
);

   typedef struct packed {
      logic [SOFT_W-1:0] softbit;
      logic              last;
   } softbit_entry_type;

   softbit_entry_type expected_softbits[$];
   logic [BPS_W-1:0]  bits_per_symbol;
   logic [QMAX_W-1:0] quant_max;

   initial begin
      mismatches       = 0;
      outstanding      = 0;
      softbits_checked = 0;
   end

   // half-up rounding of scale*conf/q, saturating at the ends of the byte
   function automatic logic [SOFT_W-1:0] map_softbit(input logic bit_value,
                                                     input logic [CONF_W-1:0] conf,
                                                     input logic [QMAX_W-1:0] qmax);
      int unsigned q;
      int unsigned c;
      int unsigned rounded;
      q = (qmax == 0) ? 1 : qmax;
      c = conf;
      if (bit_value) begin
         rounded = (2 * ONE_LIMIT * c + q) / (2 * q);
         return (rounded > ONE_LIMIT) ? SOFT_TOP : SOFT_W'(SOFT_CENTER + rounded);
      end
      rounded = (2 * ZERO_LIMIT * c + q) / (2 * q);
      return (rounded >= ZERO_LIMIT) ? SOFT_BOTTOM : SOFT_W'(SOFT_CENTER - rounded);
   endfunction

   task automatic expand_symbol(input logic [SYM_W-1:0] symbol,
                                input logic [CONF_W-1:0] confidence);
      int unsigned       nbits;
      softbit_entry_type entry;
      nbits = (bits_per_symbol > MAX_BITS) ? MAX_BITS : bits_per_symbol;
      for (int j = 0; j < nbits; j++) begin
         entry.softbit = map_softbit(symbol[j], confidence, quant_max);
         entry.last    = (j + 1 == nbits);
         expected_softbits.push_back(entry);
      end
   endtask

   task automatic check_softbit(input logic [SOFT_W-1:0] softbit, input logic last);
      softbit_entry_type entry;
      softbits_checked++;
      if (expected_softbits.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("soft bit %0d: got softbit %0d last %0b with nothing expected",
                     softbits_checked, softbit, last);
      end else begin
         entry = expected_softbits.pop_front();
         if (softbit !== entry.softbit || last !== entry.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("soft bit %0d: expected softbit %0d last %0b, got softbit %0d last %0b",
                        softbits_checked, entry.softbit, entry.last, softbit, last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bits_per_symbol = BPS_RESET;
         quant_max       = QMAX_RESET;
         expected_softbits.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BITS_PER_SYMBOL: bits_per_symbol = csr_wdata[BPS_W-1:0];
               CSR_QUANT_MAX:       quant_max = csr_wdata[QMAX_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expand_symbol(req_mon.symbol, req_mon.confidence);
         if (rsp_mon.valid && rsp_mon.ready)
            check_softbit(rsp_mon.softbit, rsp_mon.last);
      end
      outstanding = expected_softbits.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
   import stbs_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 11;
   localparam int ITEMS_PER_PHASE = 31;
   localparam int RANDOM_ITEMS    = 310;
   // dropped symbols can still be in the front end when the last soft bit leaves
   localparam int SETTLE_CYCLES   = 30;
   // longest quiet stretch: a long stall or gap plus pipeline and settle time
   localparam int WATCHDOG_LIMIT  = 2000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatches;
   int outstanding;
   int softbits_checked;
   int symbols_sent;
   int settings_used;
   int idle_cycles;
   int stall_left;
   bit steady_phase;   // no gaps and no stalls while set

   stbs_req_if req_if ();
   stbs_rsp_if rsp_if ();

   symbol_to_soft_bits_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   stbs_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .softbits_checked (softbits_checked)
   );

   always #HALF_PERIOD clock = ~clock;

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random back-pressure, changed on the falling edge
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!steady_phase && !reset && $urandom_range(0, 99) < 25) begin
         stall_left = idle_length() - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // watchdog: any transfer or register write restarts the count
   always @(posedge clock) begin
      if (reset || csr_we || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles, %0d soft bits still expected",
                  idle_cycles, outstanding);
         $display("[symbol_to_soft_bits_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one symbol transfer; valid stays up across back-to-back items
   task automatic send_symbol(input logic [SYM_W-1:0] symbol,
                              input logic [CONF_W-1:0] confidence);
      int gap;
      gap = (steady_phase || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.symbol     <= symbol;
      req_if.confidence <= confidence;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      symbols_sent++;
   endtask

   // sender goes quiet until every soft bit is back, then waits extra cycles
   task automatic drain(input int extra);
      @(negedge clock);
      req_if.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // upper bits of the bits-per-symbol write carry junk that must be ignored
   task automatic set_config(input logic [BPS_W-1:0] bps, input logic [QMAX_W-1:0] qmax);
      logic [CSR_DATA_W-1:0] data;
      data            = CSR_DATA_W'($urandom);
      data[BPS_W-1:0] = bps;
      write_csr(CSR_BITS_PER_SYMBOL, data);
      write_csr(CSR_QUANT_MAX, qmax);
      settings_used++;
   endtask

   initial begin
      int                counted;
      int                qeff;
      logic [BPS_W-1:0]  bps;
      logic [QMAX_W-1:0] qmax;
      logic [CONF_W-1:0] conf;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_BITS_PER_SYMBOL;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.symbol     = '0;
      req_if.confidence = '0;
      rsp_if.ready      = 1'b0;
      stall_left        = 0;
      steady_phase      = 1'b0;
      idle_cycles       = 0;
      symbols_sent      = 0;
      settings_used     = 1;
      counted           = 0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // reset setting: two bits, quant_max 7; zero confidence, full scale, saturation
      send_symbol(8'h03, 8'd0);
      send_symbol(8'h01, 8'd7);
      send_symbol(8'h02, 8'd3);
      send_symbol(8'h01, 8'd255);
      send_symbol(8'h02, 8'd200);
      drain(SETTLE_CYCLES);

      // all eight bits, widest quant_max
      set_config(4'd8, 8'd255);
      send_symbol(8'hff, 8'd255);
      send_symbol(8'h00, 8'd255);
      send_symbol(8'ha5, 8'd128);
      send_symbol(8'h5a, 8'd1);
      drain(SETTLE_CYCLES);

      // zero bits per symbol: symbols vanish without a soft bit
      set_config(4'd0, 8'd50);
      send_symbol(8'hff, 8'd50);
      send_symbol(8'h00, 8'd0);
      drain(SETTLE_CYCLES);

      // bits per symbol past eight with quant_max zero acting as one
      set_config(4'd15, 8'd0);
      send_symbol(8'h55, 8'd0);
      send_symbol(8'haa, 8'd1);
      send_symbol(8'hff, 8'd255);
      drain(SETTLE_CYCLES);

      // single bit, quant_max one
      set_config(4'd1, 8'd1);
      send_symbol(8'h01, 8'd1);
      send_symbol(8'h00, 8'd1);
      send_symbol(8'hfe, 8'd0);
      send_symbol(8'h01, 8'd2);
      drain(SETTLE_CYCLES);

      // an exact half rounds up in 127/2; 128/2 comes out whole
      set_config(4'd9, 8'd2);
      send_symbol(8'h3c, 8'd1);
      send_symbol(8'hc3, 8'd1);
      drain(SETTLE_CYCLES);

      // random phases, each under its own register setting
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            8:       bps = BPS_W'($urandom_range(9, 15));
            9:       bps = '0;
            default: bps = BPS_W'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 9))
            0:       qmax = '0;
            1:       qmax = 8'd1;
            2:       qmax = 8'd255;
            default: qmax = QMAX_W'($urandom_range(1, 255));
         endcase
         qeff = (qmax == 0) ? 1 : qmax;
         set_config(bps, qmax);
         steady_phase = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // hold the sender back mid-phase until the results catch up
            if (i == ITEMS_PER_PHASE / 2 && (counted == 0 || $urandom_range(0, 1) == 1))
               drain(0);
            if ($urandom_range(0, 99) < 70)
               conf = CONF_W'($urandom_range(0, qeff));
            else
               conf = CONF_W'($urandom_range(0, 255));
            send_symbol(SYM_W'($urandom_range(0, 255)), conf);
         end
         if (bps != 0)
            counted += ITEMS_PER_PHASE;
         drain(SETTLE_CYCLES);
         steady_phase = 1'b0;
      end

      $display("covered %0d symbols under %0d register settings, %0d soft bits checked",
               symbols_sent, settings_used, softbits_checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[symbol_to_soft_bits_unit] OK");
      end else begin
         $display("%0d mismatches, %0d soft bits never arrived", mismatches, outstanding);
         $display("[symbol_to_soft_bits_unit] ERROR");
      end
      $finish;
   end

endmodule
